/* rtl/core/triangle_barycentric_interpolate_core_defines.svh */
// ----------------------------------------------------------------------------
// Triangle barycentric interpolate core - assertion macros
// Shared assertion macros for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_INTERPOLATE_CORE_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_INTERPOLATE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TBI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TBI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tbi_pkg.sv */
// ----------------------------------------------------------------------------
// tbi_pkg
// Types, widths and helpers shared by the barycentric interpolate core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbi_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int PROD_W  = 66;
	localparam int CROSS_W = 67;
	localparam int MAG_W   = 66;
	localparam int IN_W    = 11 * COORD_W;
	localparam int OUT_W   = 3 * COORD_W;

	typedef logic [2:0][COORD_W-1:0] coord3_t;
	typedef logic [2:0][CROSS_W-1:0] cross3_t;

	typedef struct packed {
		coord3_t x;
		coord3_t y;
		coord3_t z;
	} verts_t;

	typedef struct packed {
		cross3_t c;
		verts_t  v;
	} side_t;

	function automatic logic signed [DIFF_W-1:0] sub_ext(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

endpackage

/* rtl/core/tbi_front.sv */
// ----------------------------------------------------------------------------
// tbi_front
// Edge and point differences, cross products and the squared 3D cross length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbi_front import tbi_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int TW = MAG_W - FRAC_BITS,
	localparam int SUM_W = 2 * TW + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  verts_t              verts_i,
	input  logic [COORD_W-1:0]  qx_i,
	input  logic [COORD_W-1:0]  qz_i,
	output logic                vld_o,
	output logic [SUM_W-1:0]    sum_o,
	output side_t               side_o
);

	localparam int H    = (TW + 1) / 2;
	localparam int HW   = TW - H;
	localparam int SQ_W = 2 * TW;

	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [DIFF_W-1:0]   n_s1 [3];
	logic signed [DIFF_W-1:0]   m_s1 [3];
	logic signed [DIFF_W-1:0]   fx_s1 [3];
	logic signed [DIFF_W-1:0]   fz_s1 [3];
	verts_t                     v_s1, v_s2;
	logic signed [PROD_W-1:0]   pa_s2 [3];
	logic signed [PROD_W-1:0]   pb_s2 [3];
	logic signed [PROD_W-1:0]   qa_s2 [3];
	logic signed [PROD_W-1:0]   qb_s2 [3];
	cross3_t                    comp_s3;
	side_t                      sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;
	logic [TW-1:0]              t_s4 [3];
	logic [2*HW-1:0]            hh_s5 [3];
	logic [HW+H-1:0]            hl_s5 [3];
	logic [2*H-1:0]             ll_s5 [3];
	logic [SQ_W-1:0]            sq_s6 [3];
	logic [SUM_W-1:0]           sum_s7;
	logic [CROSS_W-1:0]         mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = comp_s3[i][CROSS_W-1] ? (~comp_s3[i] + 1'b1) : comp_s3[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1[0] <= sub_ext(verts_i.x[1], verts_i.x[0]);
			n_s1[1] <= sub_ext(verts_i.y[1], verts_i.y[0]);
			n_s1[2] <= sub_ext(verts_i.z[1], verts_i.z[0]);
			m_s1[0] <= sub_ext(verts_i.x[2], verts_i.x[0]);
			m_s1[1] <= sub_ext(verts_i.y[2], verts_i.y[0]);
			m_s1[2] <= sub_ext(verts_i.z[2], verts_i.z[0]);
			for (int i = 0; i < 3; i++) begin
				fx_s1[i] <= sub_ext(verts_i.x[i], qx_i);
				fz_s1[i] <= sub_ext(verts_i.z[i], qz_i);
			end
			v_s1 <= verts_i;

			pa_s2[0] <= n_s1[1] * m_s1[2];
			pb_s2[0] <= n_s1[2] * m_s1[1];
			pa_s2[1] <= n_s1[2] * m_s1[0];
			pb_s2[1] <= n_s1[0] * m_s1[2];
			pa_s2[2] <= n_s1[0] * m_s1[1];
			pb_s2[2] <= n_s1[1] * m_s1[0];
			qa_s2[0] <= fx_s1[1] * fz_s1[2];
			qb_s2[0] <= fz_s1[1] * fx_s1[2];
			qa_s2[1] <= fx_s1[2] * fz_s1[0];
			qb_s2[1] <= fz_s1[2] * fx_s1[0];
			qa_s2[2] <= fx_s1[0] * fz_s1[1];
			qb_s2[2] <= fz_s1[0] * fx_s1[1];
			v_s2 <= v_s1;

			for (int i = 0; i < 3; i++) begin
				comp_s3[i] <= CROSS_W'(pa_s2[i]) - CROSS_W'(pb_s2[i]);
				sd_s3.c[i] <= CROSS_W'(qa_s2[i]) - CROSS_W'(qb_s2[i]);
			end
			sd_s3.v <= v_s2;

			for (int i = 0; i < 3; i++) begin
				t_s4[i] <= mag[i][MAG_W-1:FRAC_BITS];
			end
			sd_s4 <= sd_s3;

			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= t_s4[i][TW-1:H] * t_s4[i][TW-1:H];
				hl_s5[i] <= t_s4[i][TW-1:H] * t_s4[i][H-1:0];
				ll_s5[i] <= t_s4[i][H-1:0] * t_s4[i][H-1:0];
			end
			sd_s5 <= sd_s4;

			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (SQ_W'(hh_s5[i]) << (2 * H)) + (SQ_W'(hl_s5[i]) << (H + 1))
					+ SQ_W'(ll_s5[i]);
			end
			sd_s6 <= sd_s5;

			sum_s7 <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
			sd_s7  <= sd_s6;
		end
	end

	assign vld_o  = vld_s7;
	assign sum_o  = sum_s7;
	assign side_o = sd_s7;

endmodule

/* rtl/core/tbi_sqrt.sv */
// ----------------------------------------------------------------------------
// tbi_sqrt
// Pipelined integer square root, one root bit per stage, side data alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbi_sqrt import tbi_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int TW = MAG_W - FRAC_BITS,
	localparam int SUM_W = 2 * TW + 2,
	localparam int RW = TW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [SUM_W-1:0]  sum_i,
	input  side_t             side_i,
	output logic              vld_o,
	output logic [RW-1:0]     root_o,
	output side_t             side_o
);

	logic              vld_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [SUM_W-1:0]  rem_s  [RW];
	side_t             side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_bit
		localparam int B = RW - 1 - k;
		logic              vld_in;
		logic [RW-1:0]     root_in;
		logic [SUM_W-1:0]  rem_in;
		side_t             side_in;
		logic [SUM_W:0]    trial;

		if (k == 0) begin : g_first
			assign vld_in  = vld_i;
			assign root_in = '0;
			assign rem_in  = sum_i;
			assign side_in = side_i;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign root_in = root_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			trial = (SUM_W + 1)'(root_in) << (B + 1);
			trial[2*B] = 1'b1;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					rem_s[k]  <= rem_in - trial[SUM_W-1:0];
					root_s[k] <= root_in | (RW'(1) << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
				side_s[k] <= side_in;
			end
		end
	end

	assign vld_o  = vld_s[RW-1];
	assign root_o = root_s[RW-1];
	assign side_o = side_s[RW-1];

endmodule

/* rtl/core/tbi_div.sv */
// ----------------------------------------------------------------------------
// tbi_div
// Range check of the 2D crosses and pipelined division into the three weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbi_div import tbi_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int RW = MAG_W - FRAC_BITS + 1,
	localparam int WW = FRAC_BITS + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic [RW-1:0]       v_i,
	input  side_t               side_i,
	output logic                vld_o,
	output logic                ins_o,
	output logic [2:0][WW-1:0]  w_o,
	output verts_t              verts_o
);

	localparam int NQ = FRAC_BITS + 1;

	logic [CROSS_W-1:0]   mag [3];
	logic [2:0]           bad;
	logic [CROSS_W-1:0]   lim;

	logic                 vld_s0, ins_s0;
	logic [CROSS_W-1:0]   rem_s0 [3];
	logic [RW-1:0]        v_s0;
	verts_t               vt_s0;

	logic                 vld_s   [NQ];
	logic                 ins_s   [NQ];
	logic [CROSS_W-1:0]   rem_s   [NQ][3];
	logic [WW-1:0]        q_s     [NQ][3];
	logic [RW-1:0]        v_s     [NQ];
	verts_t               vt_s    [NQ];

	always_comb begin
		lim = CROSS_W'(v_i) << FRAC_BITS;
		for (int j = 0; j < 3; j++) begin
			mag[j] = side_i.c[j][CROSS_W-1] ? (~side_i.c[j] + 1'b1) : side_i.c[j];
			bad[j] = side_i.c[j][CROSS_W-1] || (mag[j] > lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ins_s0 <= (v_i != '0) && (bad == '0);
			for (int j = 0; j < 3; j++) begin
				rem_s0[j] <= mag[j];
			end
			v_s0  <= v_i;
			vt_s0 <= side_i.v;
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_bit
		localparam int B = FRAC_BITS - k;
		logic                vld_in, ins_in;
		logic [CROSS_W-1:0]  rem_in [3];
		logic [WW-1:0]       q_in   [3];
		logic [RW-1:0]       v_in;
		verts_t              vt_in;
		logic [CROSS_W-1:0]  dv;

		if (k == 0) begin : g_first
			assign vld_in = vld_s0;
			assign ins_in = ins_s0;
			assign rem_in = rem_s0;
			assign q_in   = '{default: '0};
			assign v_in   = v_s0;
			assign vt_in  = vt_s0;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign ins_in = ins_s[k-1];
			assign rem_in = rem_s[k-1];
			assign q_in   = q_s[k-1];
			assign v_in   = v_s[k-1];
			assign vt_in  = vt_s[k-1];
		end

		assign dv = CROSS_W'(v_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (rem_in[j] >= dv) begin
						rem_s[k][j] <= rem_in[j] - dv;
						q_s[k][j]   <= q_in[j] | (WW'(1) << B);
					end else begin
						rem_s[k][j] <= rem_in[j];
						q_s[k][j]   <= q_in[j];
					end
				end
				ins_s[k] <= ins_in;
				v_s[k]   <= v_in;
				vt_s[k]  <= vt_in;
			end
		end
	end

	assign vld_o   = vld_s[NQ-1];
	assign ins_o   = ins_s[NQ-1];
	assign w_o[0]  = q_s[NQ-1][0];
	assign w_o[1]  = q_s[NQ-1][1];
	assign w_o[2]  = q_s[NQ-1][2];
	assign verts_o = vt_s[NQ-1];

endmodule

/* rtl/core/tbi_blend.sv */
// ----------------------------------------------------------------------------
// tbi_blend
// Weighted sum of the vertices, floor shift, saturation and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbi_blend import tbi_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int WW = FRAC_BITS + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic                ins_i,
	input  logic [2:0][WW-1:0]  w_i,
	input  verts_t              verts_i,
	output logic                vld_o,
	output logic                ins_o,
	output coord3_t             out_o
);

	localparam int P_W   = WW + 1 + COORD_W;
	localparam int ACC_W = P_W + 2;

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     ins_s1, ins_s2, ins_s3;
	logic signed [P_W-1:0]    p_s1 [3][3];
	logic signed [ACC_W-1:0]  acc_s2 [3];
	coord3_t                  out_s3;
	coord3_t                  coord [3];
	logic signed [ACC_W-1:0]  sh [3];
	coord3_t                  sat;

	assign coord[0] = verts_i.x;
	assign coord[1] = verts_i.y;
	assign coord[2] = verts_i.z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sh[a] = acc_s2[a] >>> FRAC_BITS;
			if (!ins_s2) begin
				sat[a] = '0;
			end else if ((&sh[a][ACC_W-1:COORD_W-1]) || !(|sh[a][ACC_W-1:COORD_W-1])) begin
				sat[a] = sh[a][COORD_W-1:0];
			end else if (sh[a][ACC_W-1]) begin
				sat[a] = {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				sat[a] = {1'b0, {(COORD_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					p_s1[a][i] <= $signed({1'b0, w_i[i]}) * $signed(coord[a][i]);
				end
			end
			ins_s1 <= ins_i;
			for (int a = 0; a < 3; a++) begin
				acc_s2[a] <= ACC_W'(p_s1[a][0]) + ACC_W'(p_s1[a][1]) + ACC_W'(p_s1[a][2]);
			end
			ins_s2 <= ins_s1;
			out_s3 <= sat;
			ins_s3 <= ins_s2;
		end
	end

	assign vld_o = vld_s3;
	assign ins_o = ins_s3;
	assign out_o = out_s3;

endmodule

/* rtl/core/triangle_barycentric_interpolate_core.sv */
// ----------------------------------------------------------------------------
// triangle_barycentric_interpolate_core
// Throughput: one item per cycle while the output is not stalled; the
// bit-per-stage root and divider set depth, which does not depend on FRAC_BITS.
// Reset clears all stage valid bits; a stalled output holds every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_barycentric_interpolate_core_defines.svh"

module triangle_barycentric_interpolate_core import tbi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, query_x, query_z
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// out_x, out_y, out_z
	output logic [OUT_W-1:0]  m_tdata,
	// inside_res
	output logic              m_tuser
);

	localparam int TW    = MAG_W - FRAC_BITS;
	localparam int SUM_W = 2 * TW + 2;
	localparam int RW    = TW + 1;
	localparam int WW    = FRAC_BITS + 1;
	localparam logic [WW-1:0] W_MAX = WW'(1) << FRAC_BITS;

	logic               en;
	verts_t             verts_in;
	logic               fr_vld, sq_vld, dv_vld, dv_ins;
	logic [SUM_W-1:0]   fr_sum;
	side_t              fr_side, sq_side;
	logic [RW-1:0]      sq_root;
	logic [2:0][WW-1:0] dv_w;
	verts_t             dv_verts;
	coord3_t            bl_out;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign verts_in.x[i] = s_tdata[(3*i)*COORD_W +: COORD_W];
		assign verts_in.y[i] = s_tdata[(3*i+1)*COORD_W +: COORD_W];
		assign verts_in.z[i] = s_tdata[(3*i+2)*COORD_W +: COORD_W];
	end

	tbi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (s_tvalid),
		.verts_i (verts_in),
		.qx_i    (s_tdata[9*COORD_W +: COORD_W]),
		.qz_i    (s_tdata[10*COORD_W +: COORD_W]),
		.vld_o   (fr_vld),
		.sum_o   (fr_sum),
		.side_o  (fr_side)
	);

	tbi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (fr_vld),
		.sum_i   (fr_sum),
		.side_i  (fr_side),
		.vld_o   (sq_vld),
		.root_o  (sq_root),
		.side_o  (sq_side)
	);

	tbi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (sq_vld),
		.v_i     (sq_root),
		.side_i  (sq_side),
		.vld_o   (dv_vld),
		.ins_o   (dv_ins),
		.w_o     (dv_w),
		.verts_o (dv_verts)
	);

	tbi_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (dv_vld),
		.ins_i   (dv_ins),
		.w_i     (dv_w),
		.verts_i (dv_verts),
		.vld_o   (m_tvalid),
		.ins_o   (m_tuser),
		.out_o   (bl_out)
	);

	assign m_tdata = {bl_out[2], bl_out[1], bl_out[0]};

	`TBI_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss item carries data")
	`TBI_ASSERT_IMP(a_stall_input, m_tvalid && !m_tready, !s_tready, "input taken during stall")
	`TBI_ASSERT_IMP(a_weight_range, dv_vld && dv_ins, (dv_w[0] <= W_MAX) && (dv_w[1] <= W_MAX) && (dv_w[2] <= W_MAX), "weight above one")

endmodule

/* sim/triangle_barycentric_interpolate_core_tb.sv */
// ----------------------------------------------------------------------------
// triangle_barycentric_interpolate_core_tb
// Streams triangle and query-point items through the core under random input
// gaps and output stalls, and checks every result item against an in-bench
// barycentric height predictor, field by field and in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_barycentric_interpolate_core_tb;
	import tbi_pkg::*;

	localparam int FRAC      = 16;
	localparam int LATENCY   = 79;
	localparam int LIMIT     = 600000;
	localparam int N_RANDOM  = 2000;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} height_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	logic [IN_W-1:0] tri_q[$];
	bit              drain_q[$];
	height_t         height_q[$];
	int              errors;
	int              cycles;
	int              burst_left;
	int              gap_left;
	int              holdoff;
	bit              holdoff_done;
	int              stall_mode;

	triangle_barycentric_interpolate_core #(.FRAC_BITS(FRAC)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic wide_t coord(input logic [IN_W-1:0] d, input int idx);
		return wide_t'($signed(d[idx*COORD_W +: COORD_W]));
	endfunction

	function automatic logic signed [COORD_W-1:0] floor_sat(input wide_t acc);
		wide_t s;
		s = acc >>> FRAC;
		if (s > 64'sd2147483647) return 32'sh7fffffff;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return s[COORD_W-1:0];
	endfunction

	function automatic height_t interpolate_height(input logic [IN_W-1:0] d);
		wide_t   vx[3], vy[3], vz[3], fx[3], fz[3], wt[3];
		wide_t   nx, ny, nz, mx, my, mz, cr, t, sum, root, cand, lim, ax, ay, az;
		wide_t   comp[3];
		height_t h;
		int      j, k;
		h = '0;
		for (int i = 0; i < 3; i++) begin
			vx[i] = coord(d, 3*i);
			vy[i] = coord(d, 3*i + 1);
			vz[i] = coord(d, 3*i + 2);
		end
		nx = vx[1] - vx[0]; ny = vy[1] - vy[0]; nz = vz[1] - vz[0];
		mx = vx[2] - vx[0]; my = vy[2] - vy[0]; mz = vz[2] - vz[0];
		comp[0] = ny*mz - nz*my;
		comp[1] = nz*mx - nx*mz;
		comp[2] = nx*my - ny*mx;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			t = (comp[i] < 0) ? -comp[i] : comp[i];
			t = t >> FRAC;
			sum = sum + t*t;
		end
		root = 0;
		for (int b = 60; b >= 0; b--) begin
			cand = root | (wide_t'(1) << b);
			if (cand*cand <= sum) root = cand;
		end
		if (root == 0) return h;
		lim = root << FRAC;
		for (int i = 0; i < 3; i++) begin
			fx[i] = vx[i] - coord(d, 9);
			fz[i] = vz[i] - coord(d, 10);
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			cr = fx[j]*fz[k] - fz[j]*fx[k];
			if (cr < 0 || cr > lim) return h;
			wt[i] = cr / root;
		end
		ax = 0; ay = 0; az = 0;
		for (int i = 0; i < 3; i++) begin
			ax = ax + wt[i]*vx[i];
			ay = ay + wt[i]*vy[i];
			az = az + wt[i]*vz[i];
		end
		h.hit = 1'b1;
		h.x = floor_sat(ax);
		h.y = floor_sat(ay);
		h.z = floor_sat(az);
		return h;
	endfunction

	function automatic logic [IN_W-1:0] pack_tri(input logic [10:0][31:0] f);
		return f;
	endfunction

	function automatic logic [31:0] rand_coord();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	// triangle with the query point on a random convex combination, or all fields random with noise
	function automatic logic [IN_W-1:0] rand_triangle(input bit noise);
		logic [10:0][31:0] f;
		int                w0, w1, w2;
		for (int i = 0; i < 11; i++) f[i] = noise ? $urandom : rand_coord();
		if (!noise) begin
			w0 = $urandom_range(0, 1000);
			w1 = $urandom_range(0, 1000 - w0);
			w2 = 1000 - w0 - w1;
			f[9]  = 32'((w0*longint'($signed(f[0])) + w1*longint'($signed(f[3]))
				+ w2*longint'($signed(f[6]))) / 1000);
			f[10] = 32'((w0*longint'($signed(f[2])) + w1*longint'($signed(f[5]))
				+ w2*longint'($signed(f[8]))) / 1000);
		end
		return pack_tri(f);
	endfunction

	task automatic add_item(input logic [IN_W-1:0] d, input bit drain);
		tri_q.push_back(d);
		drain_q.push_back(drain);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (s_tvalid && s_tready) height_q.push_back(interpolate_height(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (tri_q.size() == 0 || gap_left > 0 || (drain_q[0] &&
						(height_q.size() != 0 || s_tvalid))) begin
					s_tvalid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= tri_q.pop_front();
					void'(drain_q.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			holdoff      <= 0;
			holdoff_done <= 1'b0;
			stall_mode   <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (height_q.size() == 0) begin
					$error("result item with no expectation: %h %b", m_tdata, m_tuser);
					errors++;
				end else begin
					height_t e;
					e = height_q.pop_front();
					if (m_tuser !== e.hit) begin
						$error("inside_res: expected %0d got %0d", e.hit, m_tuser);
						errors++;
					end
					if (m_tdata[31:0] !== e.x) begin
						$error("out_x: expected %h got %h", e.x, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[63:32] !== e.y) begin
						$error("out_y: expected %h got %h", e.y, m_tdata[63:32]);
						errors++;
					end
					if (m_tdata[95:64] !== e.z) begin
						$error("out_z: expected %h got %h", e.z, m_tdata[95:64]);
						errors++;
					end
				end
			end
			if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2);
			if (!holdoff_done && tri_q.size() < 1500) begin
				holdoff      <= 300;
				holdoff_done <= 1'b1;
				m_tready     <= 1'b0;
			end else if (holdoff > 0) begin
				holdoff  <= holdoff - 1;
				m_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [10:0][31:0] f;
		errors = 0;
		arst_n = 1'b0;

		// zero normaliser, all-min and all-max extremes
		add_item('0, 1'b0);
		for (int i = 0; i < 11; i++) f[i] = 32'h80000000;
		add_item(pack_tri(f), 1'b0);
		for (int i = 0; i < 11; i++) f[i] = 32'h7fffffff;
		add_item(pack_tri(f), 1'b0);
		add_item({IN_W{1'b1}}, 1'b0);
		// unit triangle in xz with a height ramp: inside, on a vertex, outside
		f = '0;
		f[3] = 32'h00010000; f[4] = 32'h00020000;
		f[8] = 32'h00010000; f[7] = 32'h00030000;
		f[9] = 32'h00004000; f[10] = 32'h00004000;
		add_item(pack_tri(f), 1'b0);
		f[9] = 32'h0; f[10] = 32'h0;
		add_item(pack_tri(f), 1'b0);
		f[9] = 32'h00020000; f[10] = 32'h00020000;
		add_item(pack_tri(f), 1'b0);
		f[9] = 32'hffff0000;
		add_item(pack_tri(f), 1'b0);
		// opposite winding
		f[3] = 32'h0; f[5] = 32'h00010000; f[6] = 32'h00010000; f[8] = 32'h0;
		f[9] = 32'h00004000; f[10] = 32'h00004000;
		add_item(pack_tri(f), 1'b0);
		// vertical triangle: zero xz area, nonzero normaliser
		f = '0;
		f[4] = 32'h00010000; f[6] = 32'h00010000;
		add_item(pack_tri(f), 1'b0);
		// collinear vertices
		f = '0;
		f[3] = 32'h00010000; f[5] = 32'h00010000;
		f[6] = 32'h00020000; f[8] = 32'h00020000;
		add_item(pack_tri(f), 1'b0);
		// huge triangle with extreme heights: saturation territory
		f[0] = 32'h80000000; f[1] = 32'h7fffffff; f[2] = 32'h80000000;
		f[3] = 32'h7fffffff; f[4] = 32'h7fffffff; f[5] = 32'h80000000;
		f[6] = 32'h80000000; f[7] = 32'h80000000; f[8] = 32'h7fffffff;
		f[9] = 32'hc0000000; f[10] = 32'hc0000000;
		add_item(pack_tri(f), 1'b0);
		f[1] = 32'h80000000; f[4] = 32'h80000000; f[7] = 32'h7fffffff;
		add_item(pack_tri(f), 1'b0);
		for (int i = 0; i < 8; i++) add_item(rand_triangle(1'b0), 1'b0);

		for (int i = 0; i < N_RANDOM; i++)
			add_item(rand_triangle($urandom_range(0, 4) == 0), (i == 1000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (tri_q.size() == 0);
		@(posedge clk);
		while (s_tvalid || height_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
